/* design/mmh_pkg.sv */
`timescale 1ns / 1ps

package mmh_pkg;

    localparam int NUM_BINS    = 1024;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = $clog2(NUM_BINS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_TRACK = 2'd0;
    localparam logic [1:0] FUNC_HIST  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] CFG_RANGE_MIN = 2'd0;
    localparam logic [1:0] CFG_BIN_SCALE = 2'd1;

    localparam logic signed [31:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_RESET = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] sample;
        logic [9:0]         bin_select;
        logic               last_sample;
    } item_t;

    typedef struct packed {
        logic signed [31:0] cur_min;
        logic signed [31:0] cur_max;
        logic [9:0]         bin_index;
        logic [31:0]        bin_count;
        logic               pass_done;
    } result_t;

    // word handed from front to back
    typedef struct packed {
        logic [1:0]         func;
        logic [BIN_W-1:0]   addr;
        logic               in_range;
        logic [9:0]         bin_index;
        logic               last;
        logic signed [31:0] cur_min;
        logic signed [31:0] cur_max;
    } qentry_t;

    typedef struct packed {
        logic [1:0] inflight;
    } front_status_t;

    function automatic logic [BIN_W-1:0] sel_addr(input logic [9:0] sel);
        logic [BIN_W+9:0] w;
        w = {{BIN_W{1'b0}}, sel};
        return w[BIN_W-1:0];
    endfunction

    function automatic logic [9:0] to_idx(input logic [BIN_W-1:0] addr);
        logic [BIN_W+9:0] w;
        w = {10'b0, addr};
        return w[9:0];
    endfunction

    function automatic logic sel_in_range(input logic [9:0] sel);
        return {22'b0, sel} < 32'(NUM_BINS);
    endfunction

    // counters wider than the result field saturate on output
    function automatic logic [31:0] count_out(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+31:0] w;
        w = {32'b0, c};
        if (w[COUNT_WIDTH+31:32] != '0)
        begin
            return 32'hFFFF_FFFF;
        end
        return w[31:0];
    endfunction

endpackage

/* design/mmh_front.sv */
`timescale 1ns / 1ps

module mmh_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   accept,
    input  mmh_pkg::item_t         item,
    output logic                   push_valid,
    output mmh_pkg::qentry_t       push_entry,
    output mmh_pkg::front_status_t status
);

    logic signed [31:0] range_min_reg;
    logic [31:0]        bin_scale_reg;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] max_reg, max_next;

    logic               s1_valid_reg;
    logic [1:0]         s1_func_reg;
    logic [31:0]        s1_diff_reg;
    logic [9:0]         s1_sel_reg;
    logic               s1_last_reg;
    logic signed [31:0] s1_min_reg;
    logic signed [31:0] s1_max_reg;

    logic               s2_valid_reg;
    logic [1:0]         s2_func_reg;
    logic [31:0]        s2_prod_reg;
    logic [9:0]         s2_sel_reg;
    logic               s2_last_reg;
    logic signed [31:0] s2_min_reg;
    logic signed [31:0] s2_max_reg;

    logic signed [32:0] diff;
    logic [31:0]        diff_pos;
    logic [63:0]        prod;
    logic [mmh_pkg::BIN_W-1:0] hist_addr;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (accept && item.func == mmh_pkg::FUNC_TRACK)
        begin
            if (item.sample < min_reg)
            begin
                min_next = item.sample;
            end
            if (item.sample > max_reg)
            begin
                max_next = item.sample;
            end
        end
    end

    // sample - range_min never exceeds 2^32-1, so a positive difference fits 32 bits
    assign diff     = {item.sample[31], item.sample} - {range_min_reg[31], range_min_reg};
    assign diff_pos = (!diff[32] && diff != '0) ? diff[31:0] : 32'd0;

    assign prod = {32'b0, s1_diff_reg} * {32'b0, bin_scale_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= '0;
            bin_scale_reg <= 32'd65536;
            min_reg       <= mmh_pkg::MIN_RESET;
            max_reg       <= mmh_pkg::MAX_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mmh_pkg::CFG_RANGE_MIN: range_min_reg <= cfg_data;
                    mmh_pkg::CFG_BIN_SCALE: bin_scale_reg <= cfg_data;
                    default: ;
                endcase
            end
            min_reg      <= min_next;
            max_reg      <= max_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= item.func;
            s1_diff_reg <= diff_pos;
            s1_sel_reg  <= item.bin_select;
            s1_last_reg <= item.last_sample;
            s1_min_reg  <= min_next;
            s1_max_reg  <= max_next;
        end
        if (s1_valid_reg)
        begin
            s2_func_reg <= s1_func_reg;
            s2_prod_reg <= prod[63:32];
            s2_sel_reg  <= s1_sel_reg;
            s2_last_reg <= s1_last_reg;
            s2_min_reg  <= s1_min_reg;
            s2_max_reg  <= s1_max_reg;
        end
    end

    // bins past the end clamp to the last one
    always_comb
    begin
        if ({1'b0, s2_prod_reg} >= 33'(mmh_pkg::NUM_BINS))
        begin
            hist_addr = mmh_pkg::BIN_W'(mmh_pkg::NUM_BINS - 1);
        end
        else
        begin
            hist_addr = s2_prod_reg[mmh_pkg::BIN_W-1:0];
        end
    end

    always_comb
    begin
        push_entry.func      = s2_func_reg;
        push_entry.last      = s2_last_reg;
        push_entry.cur_min   = s2_min_reg;
        push_entry.cur_max   = s2_max_reg;
        push_entry.addr      = '0;
        push_entry.in_range  = 1'b0;
        push_entry.bin_index = '0;
        unique case (s2_func_reg)
            mmh_pkg::FUNC_HIST:
            begin
                push_entry.addr      = hist_addr;
                push_entry.in_range  = 1'b1;
                push_entry.bin_index = mmh_pkg::to_idx(hist_addr);
            end
            mmh_pkg::FUNC_READ:
            begin
                push_entry.addr      = mmh_pkg::sel_addr(s2_sel_reg);
                push_entry.in_range  = mmh_pkg::sel_in_range(s2_sel_reg);
                push_entry.bin_index = s2_sel_reg;
            end
            default: ;
        endcase
    end

    assign push_valid      = s2_valid_reg;
    assign status.inflight = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

/* design/mmh_queue.sv */
`timescale 1ns / 1ps

module mmh_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  mmh_pkg::qentry_t           push_entry,
    input  logic                       pop,
    output logic                       head_valid,
    output mmh_pkg::qentry_t           head,
    output logic [mmh_pkg::QCNT_W-1:0] count
);

    mmh_pkg::qentry_t                 slot_reg [mmh_pkg::QUEUE_DEPTH];
    logic [mmh_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [mmh_pkg::QCNT_W-1:0]       count_reg;

    function automatic logic [mmh_pkg::QPTR_W-1:0] ptr_inc(
        input logic [mmh_pkg::QPTR_W-1:0] p);
        if (p == mmh_pkg::QPTR_W'(mmh_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

/* design/mmh_back.sv */
`timescale 1ns / 1ps

module mmh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  mmh_pkg::qentry_t   head,
    output logic               pop,
    output logic               clearing,
    output logic               result_valid,
    input  logic               result_ready,
    output mmh_pkg::result_t   result
);

    logic [mmh_pkg::COUNT_WIDTH-1:0] mem [mmh_pkg::NUM_BINS];
    logic [mmh_pkg::COUNT_WIDTH-1:0] rdata_reg;

    logic                      clr_busy_reg;
    logic [mmh_pkg::BIN_W-1:0] clr_addr_reg;

    logic                      b1_valid_reg;
    mmh_pkg::qentry_t          b1_reg;

    logic                            fwd_valid_reg;
    logic [mmh_pkg::BIN_W-1:0]       fwd_addr_reg;
    logic [mmh_pkg::COUNT_WIDTH-1:0] fwd_data_reg;

    mmh_pkg::result_t ob_reg [2];
    logic             ob_wr_reg, ob_rd_reg;
    logic [1:0]       ob_cnt_reg;
    logic             ob_pop;

    logic [mmh_pkg::COUNT_WIDTH-1:0] old_cnt, new_cnt;
    logic                            upd;
    logic                            wr_en;
    logic [mmh_pkg::BIN_W-1:0]       wr_addr;
    logic [mmh_pkg::COUNT_WIDTH-1:0] wr_data;
    mmh_pkg::result_t                res;

    assign ob_pop = result_valid && result_ready;

    // room counts the word in flight and the one leaving the buffer this cycle
    assign pop = head_valid && !clr_busy_reg
                 && ({1'b0, ob_cnt_reg} + {2'b0, b1_valid_reg} < 3'd2 + {2'b0, ob_pop});

    // memory read misses the write made at the same edge, so take it from here
    assign old_cnt = (fwd_valid_reg && fwd_addr_reg == b1_reg.addr) ? fwd_data_reg : rdata_reg;
    assign new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + mmh_pkg::COUNT_WIDTH'(1);
    assign upd     = b1_valid_reg && b1_reg.func == mmh_pkg::FUNC_HIST;

    assign wr_en   = clr_busy_reg || upd;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : b1_reg.addr;
    assign wr_data = clr_busy_reg ? '0 : new_cnt;

    always_comb
    begin
        res.cur_min   = b1_reg.cur_min;
        res.cur_max   = b1_reg.cur_max;
        res.bin_index = b1_reg.bin_index;
        res.pass_done = b1_reg.last;
        res.bin_count = '0;
        unique case (b1_reg.func)
            mmh_pkg::FUNC_HIST: res.bin_count = mmh_pkg::count_out(new_cnt);
            mmh_pkg::FUNC_READ:
            begin
                if (b1_reg.in_range)
                begin
                    res.bin_count = mmh_pkg::count_out(old_cnt);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rdata_reg <= mem[head.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            b1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            ob_wr_reg     <= 1'b0;
            ob_rd_reg     <= 1'b0;
            ob_cnt_reg    <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == mmh_pkg::BIN_W'(mmh_pkg::NUM_BINS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
            b1_valid_reg <= pop;
            if (upd)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (b1_valid_reg)
            begin
                ob_wr_reg <= ~ob_wr_reg;
            end
            if (ob_pop)
            begin
                ob_rd_reg <= ~ob_rd_reg;
            end
            if (b1_valid_reg && !ob_pop)
            begin
                ob_cnt_reg <= ob_cnt_reg + 1'b1;
            end
            else if (ob_pop && !b1_valid_reg)
            begin
                ob_cnt_reg <= ob_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_reg <= head;
        end
        if (upd)
        begin
            fwd_addr_reg <= b1_reg.addr;
            fwd_data_reg <= new_cnt;
        end
        if (b1_valid_reg)
        begin
            ob_reg[ob_wr_reg] <= res;
        end
    end

    assign clearing     = clr_busy_reg;
    assign result_valid = ob_cnt_reg != '0;
    assign result       = ob_reg[ob_rd_reg];

endmodule

/* design/min_max_histogram_engine.sv */
`timescale 1ns / 1ps
// Path: two front stages, the queue, one memory read stage and the output buffer; the result
// side can stall the path. Throughput: one item per cycle while item_ready is high;
// the bin read-modify-write forwards the last written count.
// Reset: trackers, registers and queues clear at once; the bin counters are then zeroed
// one per cycle, all 1024 of them, with item_ready low (configuration writes still taken).

module min_max_histogram_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  mmh_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output mmh_pkg::result_t result
);

    localparam int QSUM_W = mmh_pkg::QCNT_W + 1;

    logic                       accept;
    logic                       cfg_write;
    logic                       push_valid;
    mmh_pkg::qentry_t           push_entry;
    mmh_pkg::front_status_t     front_status;
    logic                       head_valid;
    mmh_pkg::qentry_t           head;
    logic [mmh_pkg::QCNT_W-1:0] q_count;
    logic                       pop;
    logic                       clearing;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // words still in the front pipeline have a queue slot reserved
    assign item_ready = !clearing
                        && (QSUM_W'(q_count) + QSUM_W'(front_status.inflight)
                            < QSUM_W'(mmh_pkg::QUEUE_DEPTH));
    assign accept = item_valid && item_ready;

    mmh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .item       (item),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .status     (front_status)
    );

    mmh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    mmh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* test/min_max_histogram_engine_tb.sv */
`timescale 1ns / 1ps

module min_max_histogram_engine_tb;

    import mmh_pkg::*;

    localparam logic [1:0] FUNC_NONE   = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int         ITEM_TARGET = 1950;

    // Running min/max and histogram predictor with its queue of due results.
    class stats_scoreboard;
        logic signed [31:0] range_lo;
        logic [31:0]        scale;
        logic signed [31:0] run_min;
        logic signed [31:0] run_max;
        logic [31:0]        counts [NUM_BINS];
        result_t            due_results [$];
        int                 errors;

        function new();
            range_lo = '0;
            scale    = 32'd65536;
            run_min  = MIN_RESET;
            run_max  = MAX_RESET;
            foreach (counts[i])
            begin
                counts[i] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [31:0] data);
            case (idx)
                CFG_RANGE_MIN: range_lo = data;
                CFG_BIN_SCALE: scale    = data;
                default:       ;
            endcase
        endfunction

        function logic [9:0] bin_of(input logic signed [31:0] s);
            longint      diff;
            logic [63:0] prod;
            logic [63:0] b;
            diff = longint'(s) - longint'(range_lo);
            if (diff <= 0)
            begin
                return '0;
            end
            prod = 64'(diff) * {32'b0, scale};
            b    = prod >> 32;
            if (b >= 64'(NUM_BINS))
            begin
                return 10'(NUM_BINS - 1);
            end
            return b[9:0];
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void predict(input item_t it);
            result_t    r;
            logic [9:0] b;
            r = '0;
            case (it.func)
                FUNC_TRACK:
                begin
                    if ($signed(it.sample) < run_min)
                    begin
                        run_min = it.sample;
                    end
                    if ($signed(it.sample) > run_max)
                    begin
                        run_max = it.sample;
                    end
                end
                FUNC_HIST:
                begin
                    b = bin_of(it.sample);
                    if (counts[b] != 32'hFFFF_FFFF)
                    begin
                        counts[b] = counts[b] + 1;
                    end
                    r.bin_index = b;
                    r.bin_count = counts[b];
                end
                FUNC_READ:
                begin
                    r.bin_index = it.bin_select;
                    r.bin_count = counts[it.bin_select];
                end
                default: ;
            endcase
            r.cur_min   = run_min;
            r.cur_max   = run_max;
            r.pass_done = it.last_sample;
            due_results.push_back(r);
        endfunction

        task report(input string msg);
            if (errors < 30)
            begin
                $display("%0t ns mismatch: %s", $time, msg);
            end
            errors++;
        endtask

        task check(input result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result word with nothing pending: %h", got));
                return;
            end
            want = due_results.pop_front();
            if (got.cur_min !== want.cur_min)
                report($sformatf("cur_min %h, want %h", got.cur_min, want.cur_min));
            if (got.cur_max !== want.cur_max)
                report($sformatf("cur_max %h, want %h", got.cur_max, want.cur_max));
            if (got.bin_index !== want.bin_index)
                report($sformatf("bin_index %0d, want %0d", got.bin_index, want.bin_index));
            if (got.bin_count !== want.bin_count)
                report($sformatf("bin_count %0d, want %0d", got.bin_count, want.bin_count));
            if (got.pass_done !== want.pass_done)
                report($sformatf("pass_done %b, want %b", got.pass_done, want.pass_done));
        endtask
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = '0;
    logic [31:0] cfg_data     = '0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;

    stats_scoreboard sb = new();
    int              sent = 0;
    bit              sender_calm = 1'b0;

    min_max_histogram_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic item_t make_word(input logic [1:0] f, input logic [31:0] s,
                                        input logic [9:0] sel, input logic last);
        item_t it;
        it.func        = f;
        it.sample      = s;
        it.bin_select  = sel;
        it.last_sample = last;
        return it;
    endfunction

    // valid stays high after acceptance; the next call or a pause decides
    task send_item(input item_t it);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_ready !== 1'b1);
        sb.predict(it);
        if (it.func != FUNC_NONE)
        begin
            sent++;
        end
    endtask

    task drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task cfg_write(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    task configure(input logic [31:0] lo, input logic [31:0] sc, input bit spare);
        drain();
        if (spare)
        begin
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        end
        if ($urandom_range(0, 1))
        begin
            cfg_write(CFG_RANGE_MIN, lo);
            cfg_write(CFG_BIN_SCALE, sc);
        end
        else
        begin
            cfg_write(CFG_BIN_SCALE, sc);
            cfg_write(CFG_RANGE_MIN, lo);
        end
        cfg_valid <= 1'b0;
    endtask

    task directed_items();
        // counters and trackers straight out of reset
        send_item(make_word(FUNC_READ, $urandom, 10'd0, 1'b0));
        send_item(make_word(FUNC_READ, $urandom, 10'd1023, 1'b0));
        send_item(make_word(FUNC_NONE, $urandom, 10'($urandom), 1'b1));
        // default range: zero base, one bin per 2^16 of sample value
        send_item(make_word(FUNC_HIST, 32'h0000_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h0000_0001, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h0005_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h0005_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'hFFFF_FFFF, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h8000_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h03FF_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h0400_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h7FFF_FFFF, 10'($urandom), 1'b1));
        send_item(make_word(FUNC_READ, $urandom, 10'd5, 1'b0));
        send_item(make_word(FUNC_READ, $urandom, 10'd1023, 1'b0));
        send_item(make_word(FUNC_READ, $urandom, 10'd0, 1'b0));
        send_item(make_word(FUNC_TRACK, 32'h0064_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_TRACK, 32'hFF9C_0000, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_TRACK, 32'h0000_0000, 10'($urandom), 1'b1));
        // widest difference times largest scale, then zero scale
        configure(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_item(make_word(FUNC_HIST, 32'h7FFF_FFFF, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h8000_0000, 10'($urandom), 1'b0));
        configure(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        send_item(make_word(FUNC_HIST, 32'h7FFF_FFFF, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_HIST, 32'h0000_0000, 10'($urandom), 1'b0));
        configure(32'h8000_0000, 32'h0000_0001, 1'b0);
        send_item(make_word(FUNC_HIST, 32'h7FFF_FFFF, 10'($urandom), 1'b1));
    endtask

    task noise_item();
        if ($urandom_range(0, 1))
            send_item(make_word(FUNC_NONE, $urandom, 10'($urandom),
                                1'($urandom_range(0, 1))));
        else
            send_item(make_word(FUNC_READ, $urandom, 10'($urandom), 1'b0));
    endtask

    // first pass tracks a window of samples, software sets the range, second
    // pass bins the same samples, then a few bins are read back
    task random_passes();
        logic signed [31:0] samples [$];
        logic signed [31:0] s;
        logic signed [31:0] base;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]        cfg_lo;
        logic [63:0]        sc64;
        longint             width;
        int                 pass_no;
        int                 n;
        int                 span;
        int                 shift;
        int                 k;
        pass_no = 0;
        while (sent < ITEM_TARGET)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            n     = $urandom_range(8, 48);
            shift = (pass_no < 24) ? 24 - pass_no : 0;
            pass_no++;
            base  = $signed($urandom) >>> shift;
            span  = $urandom_range(4, 22);
            samples.delete();
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 && $urandom_range(0, 3) == 0)
                    s = samples[$];
                else
                    s = base + $signed(32'($urandom_range(0, (1 << span) - 1)));
                samples.push_back(s);
                if ($urandom_range(0, 15) == 0)
                    noise_item();
                send_item(make_word(FUNC_TRACK, s, 10'($urandom), i == n - 1));
            end

            lo = samples[0];
            hi = samples[0];
            foreach (samples[i])
            begin
                if (samples[i] < lo) lo = samples[i];
                if (samples[i] > hi) hi = samples[i];
            end
            width  = longint'(hi) - longint'(lo) + 1;
            sc64   = (64'd1 << 42) / 64'(width);
            cfg_lo = lo;
            case ($urandom_range(0, 7))
                0:
                begin
                    cfg_lo = $urandom;
                    sc64   = {32'b0, $urandom};
                end
                1: cfg_lo = 32'(longint'(lo) + (longint'(hi) - longint'(lo)) / 2);
                2: sc64 = sc64 << $urandom_range(1, 3);
                3: sc64 = sc64 >> $urandom_range(1, 4);
                default: ;
            endcase
            if (sc64 > 64'hFFFF_FFFF)
                sc64 = 64'hFFFF_FFFF;
            configure(cfg_lo, sc64[31:0], $urandom_range(0, 3) == 0);

            sender_calm = ($urandom_range(0, 2) == 0);
            foreach (samples[i])
            begin
                if ($urandom_range(0, 15) == 0)
                    noise_item();
                send_item(make_word(FUNC_HIST, samples[i], 10'($urandom),
                                    i == samples.size() - 1));
            end
            k = $urandom_range(2, 8);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(0, 1))
                    send_item(make_word(FUNC_READ, $urandom,
                                        sb.bin_of(samples[$urandom_range(0, n - 1)]), 1'b0));
                else
                    send_item(make_word(FUNC_READ, $urandom, 10'($urandom), 1'b0));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        random_passes();
        sender_calm = 1'b0;
        // tracker extremes last, so the running min/max moves during the random part
        send_item(make_word(FUNC_TRACK, 32'h7FFF_FFFF, 10'($urandom), 1'b0));
        send_item(make_word(FUNC_TRACK, 32'h8000_0000, 10'($urandom), 1'b1));
        send_item(make_word(FUNC_READ, $urandom, 10'($urandom), 1'b0));
        drain();
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("min_max_histogram_engine_tb: PASS");
        end
        else
        begin
            $display("min_max_histogram_engine_tb: FAIL");
        end
        $finish;
    end

    // result side: random stalls per word, with calm stretches
    initial
    begin
        int stall;
        int stretch;
        bit calm;
        stretch = 0;
        calm    = 1'b0;
        forever
        begin
            if (stretch == 0)
            begin
                calm    = ($urandom_range(0, 2) == 0);
                stretch = $urandom_range(10, 80);
            end
            stretch--;
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            sb.check(result);
        end
    end

    initial
    begin
        #5_000_000;
        $display("min_max_histogram_engine_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/mmh_pkg.sv
design/mmh_front.sv
design/mmh_queue.sv
design/mmh_back.sv
design/min_max_histogram_engine.sv
test/min_max_histogram_engine_tb.sv
